>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules. Each expects i_clk and
// i_rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/uer_pkg.sv
// ---------------------------------------------------------------------------
// uer_pkg
// Types and constants for the ultrasonic echo ranger.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package uer_pkg;

    // Width of the trigger and echo tick counter
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TICK_MAX = '1;

    // Wide enough to compare half the tick count against the 15-bit limit
    localparam int HALF_EXT_W = (TIMER_BITS > 15) ? TIMER_BITS : 16;

    localparam int HALF_W = 15;
    localparam int DIST_W = 16;
    localparam int WAIT_W = 16;
    localparam logic [HALF_W-1:0] HALF_MAX = '1;
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // Distance scaling: floor(half * speed / 1000)
    //   = floor((product >> 3) / 125), done as a reciprocal multiply
    localparam int SPEED_W     = 10;
    localparam int PROD_W      = HALF_W + SPEED_W;
    localparam int QUOT_IN_W   = PROD_W - 3;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_125 = 23'd4294968;
    localparam int SCALED_W    = QUOT_IN_W + RECIP_W;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int TRIG_W  = 8;
    localparam int TOUT_W  = 16;

    typedef enum logic [1:0] {
        REG_TRIGGER_WIDTH = 2'd0,
        REG_ECHO_TIMEOUT  = 2'd1,
        REG_SOUND_SPEED   = 2'd2
    } t_reg_idx;

    localparam logic [TRIG_W-1:0]  TRIG_WIDTH_RST  = 8'd18;
    localparam logic [TOUT_W-1:0]  ECHO_TIMEOUT_RST = 16'd12000;
    localparam logic [SPEED_W-1:0] SOUND_SPEED_RST = 10'd340;

    // Measurement sequencer
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_LOW  = 3'd1,
        PH_TRIGGER   = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } t_phase;

endpackage

>>> rtl/ultrasonic_echo_ranger_core.sv
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Range finder sequencer: trigger pulse, echo width timing, timeout and
// distance scaling, one request per microsecond tick.
// ---------------------------------------------------------------------------
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------
// input    | i_in_valid / o_in_stall | i_echo_level, i_start_request
// output   | o_out_valid / i_out_stall | o_trigger_out, o_busy_res, o_done_res,
//          |                         | o_timed_out, o_half_echo_us, o_distance_mm
// config   | APB (psel, penable)     | paddr, pwdata, prdata
//
// One request per cycle while the output is not stalled; each result passes the
// input register, sequencer and product, reciprocal multiply and output stages.
// Two multipliers set the depth: half * speed, then the divide by 1000.
// Synchronous active-low reset clears the sequencer, stored results and
// registers to their defaults. A stall on a held output result holds the whole
// pipeline and raises o_in_stall in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core
    import uer_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_echo_level,
    input  logic                i_start_request,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_trigger_out,
    output logic                o_busy_res,
    output logic                o_done_res,
    output logic                o_timed_out,
    output logic [HALF_W-1:0]   o_half_echo_us,
    output logic [DIST_W-1:0]   o_distance_mm,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // Configuration registers
    logic [TRIG_W-1:0]  r_trig_width;
    logic [TOUT_W-1:0]  r_echo_timeout;
    logic [SPEED_W-1:0] r_sound_speed;

    // Sequencer state
    t_phase                r_phase, n_phase, s_phase_eff;
    logic [TIMER_BITS-1:0] r_tick, n_tick, s_tick_inc;
    logic [WAIT_W-1:0]     r_wait, n_wait, s_wait_inc;
    logic [HALF_W-1:0]     r_last_half, n_last_half;
    logic [DIST_W-1:0]     r_last_dist, n_last_dist;
    logic [HALF_EXT_W-1:0] s_half_ext;
    logic [HALF_W-1:0]     s_half_new;
    logic                  s_trig, s_done, s_tout, s_meas;

    // Pipeline
    logic                  s_en;
    logic                  r_v0, r_echo0, r_start0;
    logic                  r_v1, r_trig1, r_busy1, r_done1, r_tout1, r_upd1;
    logic [HALF_W-1:0]     r_half1;
    logic [PROD_W-1:0]     r_prod1;
    logic                  r_v2, r_trig2, r_busy2, r_done2, r_tout2, r_upd2;
    logic [HALF_W-1:0]     r_half2;
    logic [SCALED_W-1:0]   r_scaled2;
    logic                  r_v3, r_trig3, r_busy3, r_done3, r_tout3;
    logic [HALF_W-1:0]     r_half3;
    logic [DIST_W-1:0]     r_dist3;

    logic                  s_cfg_wr;
    logic [1:0]            s_reg_idx;

    // Advance every stage unless a held result blocks the output
    assign s_en       = !r_v3 || !i_out_stall;
    assign o_in_stall = !s_en;

    // -----------------------------------------------------------------------
    // Configuration port
    // -----------------------------------------------------------------------
    assign pready    = 1'b1;
    assign s_reg_idx = paddr[3:2];
    assign s_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_width   <= TRIG_WIDTH_RST;
            r_echo_timeout <= ECHO_TIMEOUT_RST;
            r_sound_speed  <= SOUND_SPEED_RST;
        end else if (s_cfg_wr) begin
            case (s_reg_idx)
                REG_TRIGGER_WIDTH: r_trig_width   <= pwdata[TRIG_W-1:0];
                REG_ECHO_TIMEOUT:  r_echo_timeout <= pwdata[TOUT_W-1:0];
                REG_SOUND_SPEED:   r_sound_speed  <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_reg_idx)
            REG_TRIGGER_WIDTH: prdata = PDATA_W'(r_trig_width);
            REG_ECHO_TIMEOUT:  prdata = PDATA_W'(r_echo_timeout);
            REG_SOUND_SPEED:   prdata = PDATA_W'(r_sound_speed);
            default:           prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Stage 0: input register
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_en) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_echo0  <= i_echo_level;
            r_start0 <= i_start_request;
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer: next state and per-tick flags
    // -----------------------------------------------------------------------
    // Fold unused phase codes into idle
    always_comb begin
        case (r_phase)
            PH_IDLE, PH_WAIT_LOW, PH_TRIGGER, PH_WAIT_RISE, PH_MEASURE:
                s_phase_eff = r_phase;
            default:
                s_phase_eff = PH_IDLE;
        endcase
    end

    assign s_tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 1'b1;
    assign s_wait_inc = (r_wait == WAIT_MAX) ? r_wait : r_wait + 1'b1;

    // Halve the echo count and clamp it to the result field
    assign s_half_ext = HALF_EXT_W'(r_tick >> 1);
    assign s_half_new = (s_half_ext > HALF_EXT_W'(HALF_MAX)) ? HALF_MAX
                                                              : s_half_ext[HALF_W-1:0];

    always_comb begin
        n_phase     = s_phase_eff;
        n_tick      = r_tick;
        n_wait      = r_wait;
        n_last_half = r_last_half;
        s_trig      = 1'b0;
        s_done      = 1'b0;
        s_tout      = 1'b0;
        s_meas      = 1'b0;
        case (s_phase_eff)
            PH_IDLE: begin
                if (r_start0) begin
                    n_tick  = '0;
                    n_phase = r_echo0 ? PH_WAIT_LOW : PH_TRIGGER;
                end
            end
            PH_WAIT_LOW: begin
                if (!r_echo0) begin
                    n_tick  = '0;
                    n_phase = PH_TRIGGER;
                end
            end
            PH_TRIGGER: begin
                s_trig = 1'b1;
                n_tick = s_tick_inc;
                if (s_tick_inc >= TIMER_BITS'(r_trig_width)) begin
                    n_wait  = '0;
                    n_tick  = '0;
                    n_phase = PH_WAIT_RISE;
                end
            end
            PH_WAIT_RISE, PH_MEASURE: begin
                n_wait = s_wait_inc;
                if (s_phase_eff == PH_MEASURE && !r_echo0) begin
                    // falling edge wins over a timeout on the same tick
                    n_last_half = s_half_new;
                    s_meas      = 1'b1;
                    s_done      = 1'b1;
                    n_phase     = PH_IDLE;
                end else begin
                    if (r_echo0) begin
                        if (s_phase_eff == PH_WAIT_RISE) begin
                            n_tick  = TIMER_BITS'(1);
                            n_phase = PH_MEASURE;
                        end else begin
                            n_tick = s_tick_inc;
                        end
                    end
                    if (s_wait_inc >= r_echo_timeout) begin
                        s_done  = 1'b1;
                        s_tout  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Commit sequencer state once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_wait      <= '0;
            r_last_half <= '0;
        end else if (r_v0 && s_en) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_wait      <= n_wait;
            r_last_half <= n_last_half;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: flags and half * speed
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_trig1 <= s_trig;
            r_busy1 <= (n_phase != PH_IDLE);
            r_done1 <= s_done;
            r_tout1 <= s_tout;
            r_upd1  <= s_meas;
            r_half1 <= n_last_half;
            r_prod1 <= PROD_W'(s_half_new) * PROD_W'(r_sound_speed);
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: divide by 1000 as (product >> 3) * ceil(2^29 / 125)
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_trig2   <= r_trig1;
            r_busy2   <= r_busy1;
            r_done2   <= r_done1;
            r_tout2   <= r_tout1;
            r_upd2    <= r_upd1 && r_v1;
            r_half2   <= r_half1;
            r_scaled2 <= SCALED_W'(r_prod1[PROD_W-1:3]) * SCALED_W'(RECIP_125);
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: output register and stored distance
    // -----------------------------------------------------------------------
    // Keep the previous distance unless a measurement completed
    assign n_last_dist = r_upd2 ? r_scaled2[RECIP_SHIFT +: DIST_W] : r_last_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3        <= 1'b0;
            r_last_dist <= '0;
        end else if (s_en) begin
            r_v3 <= r_v2;
            if (r_v2) begin
                r_last_dist <= n_last_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_trig3 <= r_trig2;
            r_busy3 <= r_busy2;
            r_done3 <= r_done2;
            r_tout3 <= r_tout2;
            r_half3 <= r_half2;
            r_dist3 <= n_last_dist;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_trigger_out  = r_trig3;
    assign o_busy_res     = r_busy3;
    assign o_done_res     = r_done3;
    assign o_timed_out    = r_tout3;
    assign o_half_echo_us = r_half3;
    assign o_distance_mm  = r_dist3;

endmodule

>>> rtl/uer_checker.sv
// ---------------------------------------------------------------------------
// uer_checker
// Port-level checks on the echo ranger result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_trigger_out,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic        i_timed_out,
    input  logic [15:0] i_distance_mm
);

    // A finished measurement leaves the block idle
    `ASSERT_SAME(a_done_not_busy, i_out_valid && i_done_res, !i_busy_res, "done while busy")

    // Timeout is only reported as a completion
    `ASSERT_SAME(a_tout_with_done, i_out_valid && i_timed_out, i_done_res, "timeout without done")

    // The trigger pulse belongs to a measurement in progress
    `ASSERT_SAME(a_trig_busy, i_out_valid && i_trigger_out, i_busy_res && !i_done_res, "trigger while idle")

    // A stalled result stays in place
    `ASSERT_NEXT(a_stall_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_distance_mm), "stalled result changed")

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_trigger_out (o_trigger_out),
    .i_busy_res    (o_busy_res),
    .i_done_res    (o_done_res),
    .i_timed_out   (o_timed_out),
    .i_distance_mm (o_distance_mm)
);

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the ultrasonic echo ranger core. Measurement
// sequences (start, wait for low echo, trigger, rise delay, echo pulse) run
// through several register settings with random idling on both channels.
// A scoreboard predicts every per-tick result and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import uer_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int SHOWN_LIMIT = 10;

    // One per-tick result as it leaves the core
    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic              tout;
        logic [HALF_W-1:0] half;
        logic [DIST_W-1:0] distance;
    } tick_result_t;

    // Predict the sequencer and hold expected tick results in order
    class range_scoreboard;
        logic [TRIG_W-1:0]     trig_width;
        logic [TOUT_W-1:0]     echo_timeout;
        logic [SPEED_W-1:0]    speed;
        t_phase                phase;
        logic [TIMER_BITS-1:0] tick_count;
        logic [WAIT_W-1:0]     wait_count;
        logic [HALF_W-1:0]     last_half;
        logic [DIST_W-1:0]     last_dist;
        tick_result_t          predicted_ticks[$];
        int accepted;
        int checked;
        int failures;
        int finished;
        int timeouts;

        function new();
            trig_width   = TRIG_WIDTH_RST;
            echo_timeout = ECHO_TIMEOUT_RST;
            speed        = SOUND_SPEED_RST;
            phase        = PH_IDLE;
            tick_count   = '0;
            wait_count   = '0;
            last_half    = '0;
            last_dist    = '0;
            accepted     = 0;
            checked      = 0;
            failures     = 0;
            finished     = 0;
            timeouts     = 0;
        endfunction

        function int pending();
            return predicted_ticks.size();
        endfunction

        function void set_register(t_reg_idx idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_TRIGGER_WIDTH: trig_width = value[TRIG_W-1:0];
                REG_ECHO_TIMEOUT:  echo_timeout = value[TOUT_W-1:0];
                REG_SOUND_SPEED:   speed = value[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the sequencer by one tick and queue the result it gives
        function void note_request(logic echo, logic start);
            tick_result_t r;
            int unsigned  h;
            int unsigned  d;
            r = '0;
            accepted++;
            case (phase)
                PH_IDLE: begin
                    if (start) begin
                        tick_count = '0;
                        phase = echo ? PH_WAIT_LOW : PH_TRIGGER;
                    end
                end
                PH_WAIT_LOW: begin
                    if (!echo) begin
                        tick_count = '0;
                        phase = PH_TRIGGER;
                    end
                end
                PH_TRIGGER: begin
                    r.trigger = 1'b1;
                    if (tick_count != TICK_MAX)
                        tick_count++;
                    if (tick_count >= trig_width) begin
                        wait_count = '0;
                        tick_count = '0;
                        phase = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE, PH_MEASURE: begin
                    if (wait_count != WAIT_MAX)
                        wait_count++;
                    if (phase == PH_MEASURE && !echo) begin
                        // falling edge: store half width and scaled distance
                        h = 32'(tick_count >> 1);
                        if (h > HALF_MAX)
                            h = HALF_MAX;
                        d = (h * speed) / 1000;
                        if (d > {DIST_W{1'b1}})
                            d = {DIST_W{1'b1}};
                        last_half = h[HALF_W-1:0];
                        last_dist = d[DIST_W-1:0];
                        r.done = 1'b1;
                        phase = PH_IDLE;
                    end else begin
                        if (echo) begin
                            if (phase == PH_WAIT_RISE) begin
                                tick_count = TIMER_BITS'(1);
                                phase = PH_MEASURE;
                            end else if (tick_count != TICK_MAX) begin
                                tick_count++;
                            end
                        end
                        if (wait_count >= echo_timeout) begin
                            r.done = 1'b1;
                            r.tout = 1'b1;
                            phase = PH_IDLE;
                        end
                    end
                end
                default: phase = PH_IDLE;
            endcase
            r.busy     = (phase != PH_IDLE);
            r.half     = last_half;
            r.distance = last_dist;
            if (r.done)
                finished++;
            if (r.tout)
                timeouts++;
            predicted_ticks.push_back(r);
        endfunction

        function string show(tick_result_t t);
            return $sformatf("trig=%0b busy=%0b done=%0b tout=%0b half=%0d dist=%0d",
                             t.trigger, t.busy, t.done, t.tout, t.half, t.distance);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= SHOWN_LIMIT)
                $display("ERROR: %s", msg);
        endfunction

        // Compare one result against the oldest prediction
        function void check_result(tick_result_t got);
            tick_result_t exp_t;
            string        bad;
            if (predicted_ticks.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", show(got)));
                return;
            end
            exp_t = predicted_ticks.pop_front();
            bad = "";
            if (got.trigger !== exp_t.trigger)   bad = {bad, " trigger_out"};
            if (got.busy !== exp_t.busy)         bad = {bad, " busy_res"};
            if (got.done !== exp_t.done)         bad = {bad, " done_res"};
            if (got.tout !== exp_t.tout)         bad = {bad, " timed_out"};
            if (got.half !== exp_t.half)         bad = {bad, " half_echo_us"};
            if (got.distance !== exp_t.distance) bad = {bad, " distance_mm"};
            if (bad != "")
                note_failure($sformatf("result %0d differs in%s: expected %s, got %s",
                                       checked, bad, show(exp_t), show(got)));
            checked++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_echo_level;
    logic               i_start_request;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_trigger_out;
    logic               o_busy_res;
    logic               o_done_res;
    logic               o_timed_out;
    logic [HALF_W-1:0]  o_half_echo_us;
    logic [DIST_W-1:0]  o_distance_mm;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    range_scoreboard sb;
    logic            calm;
    int              stuck_cycles = 0;

    ultrasonic_echo_ranger_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_echo_level    (i_echo_level),
        .i_start_request (i_start_request),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_trigger_out   (o_trigger_out),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_timed_out     (o_timed_out),
        .o_half_echo_us  (o_half_echo_us),
        .o_distance_mm   (o_distance_mm),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result channel at random, except in the calm stretch
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = !calm && ($urandom_range(99) < 25);
        end
    end

    // Track both handshakes and watch for a hung pipeline
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_echo_level, i_start_request);
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_trigger_out, o_busy_res, o_done_res, o_timed_out,
                                 o_half_echo_us, o_distance_mm});
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         stuck_cycles, sb.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input logic echo, input logic start);
        if (!calm && $urandom_range(99) < 17)
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_echo_level    = echo;
        i_start_request = start;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold the sender until every predicted result is back
    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One measurement: echo high before start, rise delay, pulse length
    task automatic run_echo(input int hold_high, input int rise_delay, input int pulse_len);
        int   low_ticks;
        int   rise_ticks;
        int   high_ticks;
        logic e;
        low_ticks  = 0;
        rise_ticks = 0;
        high_ticks = 0;
        send_request(hold_high > 0, 1'b1);
        while (sb.phase != PH_IDLE) begin
            case (sb.phase)
                PH_WAIT_LOW: begin
                    e = (low_ticks < hold_high);
                    low_ticks++;
                end
                PH_TRIGGER: e = 1'($urandom_range(1));
                PH_WAIT_RISE: begin
                    e = (rise_ticks >= rise_delay);
                    rise_ticks++;
                end
                default: begin
                    e = (high_ticks < pulse_len);
                    high_ticks++;
                end
            endcase
            // start is ignored while busy; toggle it anyway
            send_request(e, 1'($urandom_range(1)));
        end
    endtask

    // Pick a delay or pulse length scaled to the current timeout
    function automatic int pick_len();
        int span;
        span = (sb.echo_timeout < 300) ? int'(sb.echo_timeout) : 300;
        if ($urandom_range(9) == 0)
            return $urandom_range(span + 4);
        return $urandom_range((span < 60) ? span : 60);
    endfunction

    // Finish any open measurement, then let the pipeline empty
    task automatic settle();
        logic e;
        while (sb.phase != PH_IDLE) begin
            case (sb.phase)
                PH_WAIT_RISE: e = 1'b1;
                PH_TRIGGER:   e = 1'($urandom_range(1));
                default:      e = 1'b0;
            endcase
            send_request(e, 1'b0);
        end
        drain_results();
    endtask

    // Program all registers, then mix measurements with noise
    task automatic run_phase(input logic [TRIG_W-1:0] trig, input logic [TOUT_W-1:0] tout,
                             input logic [SPEED_W-1:0] speed, input int quota);
        int first;
        write_reg(REG_TRIGGER_WIDTH, PDATA_W'(trig));
        write_reg(REG_ECHO_TIMEOUT, PDATA_W'(tout));
        write_reg(REG_SOUND_SPEED, PDATA_W'(speed));
        first = sb.accepted;
        while (sb.accepted - first < quota) begin
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 6))
                    send_request(1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                run_echo(($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0,
                         pick_len(), pick_len());
        end
        settle();
    endtask

    initial begin
        sb              = new();
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_echo_level    = 1'b0;
        i_start_request = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero trigger width, short timeout, top speed
        write_reg(REG_TRIGGER_WIDTH, '0);
        write_reg(REG_ECHO_TIMEOUT, 32'd3);
        write_reg(REG_SOUND_SPEED, 32'd1023);
        send_request(1'b1, 1'b0);   // no start, nothing happens
        send_request(1'b1, 1'b1);   // start with echo high: wait for low
        send_request(1'b1, 1'b1);   // start while busy
        send_request(1'b0, 1'b0);   // echo low: trigger next
        send_request(1'b1, 1'b1);   // echo high in trigger is ignored
        send_request(1'b1, 1'b0);   // rising edge
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b0);   // falling edge on the timeout tick wins
        send_request(1'b0, 1'b1);   // start with echo low
        send_request(1'b0, 1'b0);
        repeat (3) send_request(1'b0, 1'b0);   // no echo: timeout
        drain_results();

        // Directed: zero timeout
        write_reg(REG_ECHO_TIMEOUT, '0);
        send_request(1'b0, 1'b1);
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b0);   // times out on first tick after trigger
        send_request(1'b1, 1'b1);
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b0);   // rising edge and timeout together
        drain_results();

        // Random measurements over several settings
        run_phase(8'd1, 16'd40, 10'd340, 260);
        run_phase(8'd255, 16'd300, 10'd1, 150);
        run_phase(8'd5, 16'd1, 10'd1023, 200);
        calm = 1'b1;
        run_phase(TRIG_W'($urandom_range(1, 20)), TOUT_W'($urandom_range(20, 120)),
                  SPEED_W'($urandom_range(1, 1023)), 250);
        calm = 1'b0;
        run_phase(8'd0, 16'd65535, 10'd512, 150);
        run_phase(TRIG_WIDTH_RST, ECHO_TIMEOUT_RST, SOUND_SPEED_RST, 200);

        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: %0d measurements ended, %0d timed out.",
                 sb.accepted, sb.checked, sb.finished, sb.timeouts);
        $display("Settings swept: zero and full trigger width, zero to full timeout, speed 1..1023.");
        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", sb.failures);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
